// ===== sv/mpr_pkg.sv =====
package mpr_pkg;

    localparam int CHANNELS = 4;
    localparam int FRAMES = 16384;
    localparam int SINE_TABLE_BITS = 8;
    localparam int ADDR_W = $clog2(FRAMES);
    localparam int POS_W = ADDR_W + 1;
    localparam int SAMPLE_W = 16;
    localparam int FRAME_W = SAMPLE_W * CHANNELS;
    localparam int CFG_W = 15;
    localparam int PHASE_W = SINE_TABLE_BITS + 1;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_ARM = 2'd1,
        CMD_DISARM = 2'd2,
        CMD_READ = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_MODE = 3'd0,
        REG_START = 3'd1,
        REG_END = 3'd2,
        REG_FADE = 3'd3,
        REG_REGION = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_OVERWRITE = 2'd0,
        MODE_OVERDUB = 2'd1,
        MODE_PUNCH = 2'd2,
        MODE_HOLD = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_SINE,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic mem_read;
        logic div_start;
        logic div_step;
        logic sine_start;
        logic sine_step;
        logic commit;
        logic result_load;
    } cmd_bus_t;

    // Datapath to controller.
    typedef struct packed {
        logic clear_done;
        logic need_fade;
        logic div_done;
        logic sine_done;
        logic is_read;
    } status_bus_t;

    localparam logic [CFG_W-1:0] END_RESET = CFG_W'(16383);
    localparam logic [CFG_W-1:0] FADE_RESET = CFG_W'(2205);

endpackage

// ===== sv/mpr_ctrl.sv =====
module mpr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  mpr_pkg::status_bus_t  status,
    output mpr_pkg::cmd_bus_t     cmd
);
    import mpr_pkg::*;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.mem_read = 1'b1;
                if (status.need_fade)
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    cmd.sine_start = 1'b1;
                    state_next = ST_SINE;
                end
            end
            ST_SINE:
            begin
                cmd.sine_step = 1'b1;
                if (status.sine_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit = 1'b1;
                    cmd.result_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/mpr_datapath.sv =====
module mpr_datapath
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [mpr_pkg::CFG_W-1:0]  cfg_data,
    input  logic [1:0]                 in_cmd,
    input  logic signed [3:0]          in_channel,
    input  logic signed [3:0]          in_trigger,
    input  logic [13:0]                in_addr,
    input  logic [mpr_pkg::FRAME_W-1:0] in_samples,
    input  mpr_pkg::cmd_bus_t          cmd,
    output mpr_pkg::status_bus_t       status,
    output logic [14:0]                frame_position,
    output logic                       recording,
    output logic [mpr_pkg::FRAME_W-1:0] read_data
);
    import mpr_pkg::*;

    // Configuration.
    logic [1:0]       mode_reg;
    logic [13:0]      start_reg;
    logic [CFG_W-1:0] fade_reg;
    logic [CFG_W-1:0] region_reg;
    logic [POS_W-1:0] eff_end_reg, eff_end_next;
    logic [CHANNELS-1:0] mask_reg, mask_next;
    logic             rec_reg, rec_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    // Captured item.
    logic [1:0]          icmd_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                addr_ok_reg;
    logic [FRAME_W-1:0]  samp_reg;
    logic                wr_reg;

    logic [FRAME_W-1:0] mem [FRAMES];
    logic [FRAME_W-1:0] rd_reg;
    logic [ADDR_W:0]    clr_reg;

    logic [FRAME_W-1:0] res_data_reg;
    logic [14:0]        res_pos_reg;
    logic               res_rec_reg;

    function automatic logic [POS_W-1:0] clamp_end(input logic [CFG_W-1:0] v);
        if ({1'b0, v} > 17'(FRAMES))
        begin
            clamp_end = POS_W'(FRAMES);
        end
        else
        begin
            clamp_end = POS_W'(v);
        end
    endfunction

    // Tick, arm and disarm control, evaluated at capture.
    logic [POS_W-1:0] t_pos;
    logic             t_rec;
    logic [POS_W-1:0] t_end;
    logic [CHANNELS-1:0] t_mask;
    logic             is_tick;

    always_comb
    begin
        is_tick = (cmd_t'(in_cmd) == CMD_TICK);
        t_pos = pos_reg;
        t_rec = rec_reg;
        t_end = eff_end_reg;
        t_mask = mask_reg;
        unique case (cmd_t'(in_cmd))
            CMD_TICK:
            begin
                if (in_trigger == -4'sd2)
                begin
                    t_rec = 1'b0;
                    t_pos = '0;
                end
                else if (in_trigger != 4'sd0)
                begin
                    if (in_trigger >= 4'sd1 && in_trigger <= 4'sd4)
                    begin
                        t_mask = CHANNELS'(1) << (in_trigger[2:0] - 3'd1);
                    end
                    t_pos = POS_W'(start_reg);
                    if (eff_end_reg == '0)
                    begin
                        t_end = POS_W'(FRAMES);
                    end
                    t_rec = 1'b1;
                end
                if (t_pos >= t_end)
                begin
                    t_pos = '0;
                    t_rec = 1'b0;
                end
            end
            CMD_ARM:
            begin
                if (in_channel == -4'sd1)
                begin
                    t_mask = '1;
                end
                else if (in_channel == 4'sd0)
                begin
                    t_mask = '0;
                end
                else if (in_channel >= 4'sd1 && in_channel <= 4'sd4)
                begin
                    t_mask = mask_reg | (CHANNELS'(1) << (in_channel[2:0] - 3'd1));
                end
            end
            CMD_DISARM:
            begin
                if (in_channel >= 4'sd1 && in_channel <= 4'sd4)
                begin
                    t_mask = mask_reg & ~(CHANNELS'(1) << (in_channel[2:0] - 3'd1));
                end
            end
            default:
            begin
            end
        endcase
    end

    // Punch gain planning on captured position.
    logic [CFG_W-1:0] fade_eff;
    logic signed [17:0] m_s, region_s, cnt_s;
    logic               fade_need;
    always_comb
    begin
        fade_eff = (fade_reg == '0) ? CFG_W'(1) : fade_reg;
        region_s = (region_reg != '0) ? 18'($signed({3'b0, region_reg}))
                 : 18'($signed({2'b0, eff_end_reg})) - 18'($signed({4'b0, start_reg}));
        m_s = 18'($signed({2'b0, pos_reg})) - 18'($signed({4'b0, start_reg}));
        if (m_s < 0)
        begin
            m_s = '0;
        end
        fade_need = 1'b1;
        cnt_s = m_s;
        if (m_s < 18'($signed({3'b0, fade_eff})))
        begin
            cnt_s = m_s;
        end
        else if (m_s >= region_s - 18'($signed({3'b0, fade_eff})))
        begin
            cnt_s = region_s - m_s;
            if (cnt_s < 0)
            begin
                cnt_s = '0;
            end
            if (cnt_s > 18'($signed({3'b0, fade_eff})))
            begin
                cnt_s = 18'($signed({3'b0, fade_eff}));
            end
        end
        else
        begin
            fade_need = 1'b0;
        end
    end

    // Restoring divider: (cnt << SINE_TABLE_BITS) / fade, quotient <= 2^bits.
    localparam int DIVIDEND_W = CFG_W + SINE_TABLE_BITS;
    localparam int DIV_CNT_W = $clog2(DIVIDEND_W + 1);
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [CFG_W:0]        rem_reg;
    logic [DIV_CNT_W-1:0]  dcnt_reg;
    logic [CFG_W:0]        rem_shift;
    always_comb
    begin
        rem_shift = {rem_reg[CFG_W-1:0], dvd_reg[DIVIDEND_W-1]};
    end

    // Sine evaluation: two phases, five Horner steps each.
    logic [16:0] sx_reg;
    logic [33:0] sx2_reg;
    logic [17:0] st_reg;
    logic [2:0]  sstep_reg;
    logic        sphase_reg;
    logic [16:0] gnew_reg, gold_reg;
    logic [PHASE_W-1:0] k_val;
    logic [16:0] x_new, x_old;
    assign k_val = dvd_reg[PHASE_W-1:0];
    assign x_new = 17'(k_val) << (16 - SINE_TABLE_BITS);
    assign x_old = 17'(PHASE_W'(1 << SINE_TABLE_BITS) - k_val) << (16 - SINE_TABLE_BITS);

    logic [35:0] sprod;
    logic [17:0] snext;
    logic [16:0] sfinal;
    always_comb
    begin
        sprod = 36'(sx2_reg[17:0]) * 36'(st_reg);
        snext = st_reg;
        unique case (sstep_reg)
            3'd0: snext = 18'd307 - 18'(sprod >> 16);
            3'd1: snext = 18'd5223 - 18'(sprod >> 16);
            3'd2: snext = 18'd42334 - 18'(sprod >> 16);
            3'd3: snext = 18'd102944 - 18'(sprod >> 16);
            default: snext = st_reg;
        endcase
        sprod = 36'(sx_reg) * 36'(st_reg);
        if ((sprod >> 16) > 36'd65536)
        begin
            sfinal = 17'd65536;
        end
        else
        begin
            sfinal = 17'(sprod >> 16);
        end
        if (sstep_reg <= 3'd3)
        begin
            sprod = 36'(sx2_reg[17:0]) * 36'(st_reg);
        end
    end

    // Per-channel mix.
    logic [FRAME_W-1:0] new_frame;
    always_comb
    begin
        logic signed [15:0] o, n;
        logic signed [16:0] sum;
        logic signed [35:0] acc;
        logic signed [35:0] shifted;
        new_frame = rd_reg;
        for (int j = 0; j < CHANNELS; j++)
        begin
            o = $signed(rd_reg[j*SAMPLE_W +: SAMPLE_W]);
            n = $signed(samp_reg[j*SAMPLE_W +: SAMPLE_W]);
            sum = 17'(o) + 17'(n);
            acc = 36'(o) * $signed({19'b0, gold_reg}) + 36'(n) * $signed({19'b0, gnew_reg})
                + 36'sd32768;
            shifted = acc >>> 16;
            if (mask_reg[j])
            begin
                case (mode_t'(mode_reg))
                    MODE_OVERWRITE: new_frame[j*SAMPLE_W +: SAMPLE_W] = n;
                    MODE_OVERDUB:
                    begin
                        if (sum > 17'sd32767)
                            new_frame[j*SAMPLE_W +: SAMPLE_W] = 16'h7FFF;
                        else if (sum < -17'sd32768)
                            new_frame[j*SAMPLE_W +: SAMPLE_W] = 16'h8000;
                        else
                            new_frame[j*SAMPLE_W +: SAMPLE_W] = sum[15:0];
                    end
                    default:
                    begin
                        if (!fade_need)
                            new_frame[j*SAMPLE_W +: SAMPLE_W] = n;
                        else if (shifted > 36'sd32767)
                            new_frame[j*SAMPLE_W +: SAMPLE_W] = 16'h7FFF;
                        else if (shifted < -36'sd32768)
                            new_frame[j*SAMPLE_W +: SAMPLE_W] = 16'h8000;
                        else
                            new_frame[j*SAMPLE_W +: SAMPLE_W] = shifted[15:0];
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        status.clear_done = clr_reg[ADDR_W];
        status.need_fade = wr_reg && (mode_t'(mode_reg) == MODE_PUNCH) && fade_need;
        status.div_done = (dcnt_reg == DIV_CNT_W'(DIVIDEND_W));
        status.sine_done = sphase_reg && (sstep_reg == 3'd4);
        status.is_read = (cmd_t'(icmd_reg) == CMD_READ);
    end

    always_comb
    begin
        eff_end_next = eff_end_reg;
        mask_next = mask_reg;
        rec_next = rec_reg;
        pos_next = pos_reg;
        if (cmd.capture)
        begin
            eff_end_next = t_end;
            mask_next = t_mask;
            rec_next = t_rec;
            pos_next = t_pos;
        end
        if (cfg_we && reg_index_t'(cfg_index) == REG_END)
        begin
            eff_end_next = clamp_end(cfg_data);
        end
        if (cmd.commit && wr_reg)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            start_reg <= '0;
            fade_reg <= FADE_RESET;
            region_reg <= '0;
            eff_end_reg <= clamp_end(END_RESET);
            mask_reg <= '1;
            rec_reg <= 1'b0;
            pos_reg <= '0;
            clr_reg <= '0;
            wr_reg <= 1'b0;
            dcnt_reg <= '0;
            sstep_reg <= '0;
            sphase_reg <= 1'b0;
        end
        else
        begin
            eff_end_reg <= eff_end_next;
            mask_reg <= mask_next;
            rec_reg <= rec_next;
            pos_reg <= pos_next;
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_MODE: mode_reg <= cfg_data[1:0];
                    REG_START: start_reg <= cfg_data[13:0];
                    REG_FADE: fade_reg <= cfg_data;
                    REG_REGION: region_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + (ADDR_W+1)'(1);
            end
            if (cmd.capture)
            begin
                wr_reg <= is_tick && t_rec && (mode_t'(mode_reg) != MODE_HOLD)
                          && (t_pos < POS_W'(FRAMES));
            end
            if (cmd.div_start)
            begin
                dcnt_reg <= '0;
            end
            else if (cmd.div_step && !status.div_done)
            begin
                dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
            end
            if (cmd.sine_start)
            begin
                sstep_reg <= '0;
                sphase_reg <= 1'b0;
            end
            else if (cmd.sine_step)
            begin
                if (sstep_reg == 3'd4)
                begin
                    sstep_reg <= '0;
                    sphase_reg <= 1'b1;
                end
                else
                begin
                    sstep_reg <= sstep_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step && !clr_reg[ADDR_W])
        begin
            mem[clr_reg[ADDR_W-1:0]] <= '0;
        end
        else if (cmd.commit && wr_reg)
        begin
            mem[pos_reg[ADDR_W-1:0]] <= new_frame;
        end
        if (cmd.mem_read)
        begin
            rd_reg <= mem[status.is_read ? addr_reg : pos_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            icmd_reg <= in_cmd;
            addr_reg <= in_addr[ADDR_W-1:0];
            addr_ok_reg <= (15'(in_addr) < 15'(FRAMES));
            samp_reg <= in_samples;
        end
        if (cmd.div_start)
        begin
            dvd_reg <= DIVIDEND_W'(cnt_s[CFG_W-1:0]) << SINE_TABLE_BITS;
            rem_reg <= '0;
        end
        else if (cmd.div_step && !status.div_done)
        begin
            if (rem_shift >= {1'b0, fade_eff})
            begin
                rem_reg <= rem_shift - {1'b0, fade_eff};
                dvd_reg <= {dvd_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                dvd_reg <= {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
        if (cmd.sine_start || (cmd.sine_step && sstep_reg == 3'd4 && !sphase_reg))
        begin
            sx_reg <= cmd.sine_start ? x_new : x_old;
            sx2_reg <= (34'(cmd.sine_start ? x_new : x_old)
                        * 34'(cmd.sine_start ? x_new : x_old)) >> 16;
            st_reg <= 18'd11;
            if (!cmd.sine_start)
            begin
                gnew_reg <= sfinal;
            end
        end
        else if (cmd.sine_step)
        begin
            if (sstep_reg == 3'd4)
            begin
                gold_reg <= sfinal;
            end
            else
            begin
                st_reg <= snext;
            end
        end
        if (cmd.result_load)
        begin
            res_pos_reg <= 15'(pos_next);
            res_rec_reg <= rec_reg;
            res_data_reg <= (status.is_read && addr_ok_reg) ? rd_reg : '0;
        end
    end

    assign frame_position = res_pos_reg;
    assign recording = res_rec_reg;
    assign read_data = res_data_reg;

endmodule

// ===== sv/multichannel_punch_recorder_top.sv =====
// Four-channel frame recorder with overwrite, overdub and crossfaded punch
// modes and a hold mode that writes nothing. After reset the 16384-frame
// memory is cleared, one frame per clock, before any item is taken;
// configuration writes are accepted throughout. Each item then passes accept,
// memory read and write, the write waiting while a result is stalled; a punch
// item inside a crossfade adds the 23-step restoring divider (plus its done
// check) that forms the fade phase and two five-step sine evaluations.
// Every item returns one result: the write position after it, the recording
// flag, and for a read command the four stored samples of that frame.
module multichannel_punch_recorder_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [14:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic signed [3:0]   channel,
    input  logic signed [3:0]   trigger,
    input  logic [13:0]         frame_address,
    input  logic signed [15:0]  sample_0,
    input  logic signed [15:0]  sample_1,
    input  logic signed [15:0]  sample_2,
    input  logic signed [15:0]  sample_3,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [14:0]         frame_position,
    output logic                recording,
    output logic signed [15:0]  read_0,
    output logic signed [15:0]  read_1,
    output logic signed [15:0]  read_2,
    output logic signed [15:0]  read_3
);
    import mpr_pkg::*;

    cmd_bus_t cbus;
    status_bus_t sbus;
    logic [FRAME_W-1:0] rdata;

    // The controller sequences each item through the shared datapath.
    mpr_ctrl u_ctrl
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(sbus),
        .cmd(cbus)
    );

    mpr_datapath u_dp
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_cmd(cmd),
        .in_channel(channel),
        .in_trigger(trigger),
        .in_addr(frame_address),
        .in_samples({sample_3, sample_2, sample_1, sample_0}),
        .cmd(cbus),
        .status(sbus),
        .frame_position(frame_position),
        .recording(recording),
        .read_data(rdata)
    );

    assign read_0 = rdata[15:0];
    assign read_1 = rdata[31:16];
    assign read_2 = rdata[47:32];
    assign read_3 = rdata[63:48];

endmodule

// ===== sv/mpr_checker.sv =====
module mpr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [14:0] frame_position,
    input logic [15:0] read_0
);

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_position) && $stable(read_0))
        else $error("stalled result changed");

    // An accepted item blocks the input on the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not blocked while busy");

    // Position never exceeds the memory depth of 16384 frames.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_position <= 15'd16384)
        else $error("position out of range");

    // A result only appears after the block was busy.
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without item");

endmodule

bind multichannel_punch_recorder_top mpr_checker u_chk
(
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .frame_position(frame_position),
    .read_0(read_0)
);
